@@ rtl/line_pixel_generator_defines.svh @@
// Assertion macros for the line pixel generator checker.
// Every macro samples on the rising edge of i_clk in the scope where it is used.
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define LPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LPG_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lpg_pkg.sv @@
`timescale 1ns / 1ps

package lpg_pkg;

    localparam int CFG_BITS       = 12;
    localparam int PIXEL_BITS     = 11;
    localparam int SLOT_BITS      = 4;
    localparam int PALETTE_SIZE   = 12;
    localparam int REG_INDEX_BITS = 1;

    localparam logic [CFG_BITS-1:0] FRAME_MAX    = 12'd2048;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd1024;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd768;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    localparam t_color PALETTE [PALETTE_SIZE] = '{
        '{8'd255, 8'd0,   8'd0},   '{8'd255, 8'd100, 8'd0},
        '{8'd255, 8'd0,   8'd100}, '{8'd255, 8'd100, 8'd100},
        '{8'd0,   8'd255, 8'd0},   '{8'd100, 8'd255, 8'd0},
        '{8'd0,   8'd255, 8'd100}, '{8'd100, 8'd255, 8'd100},
        '{8'd0,   8'd0,   8'd255}, '{8'd100, 8'd0,   8'd255},
        '{8'd0,   8'd100, 8'd255}, '{8'd100, 8'd100, 8'd255}
    };

    // Width of a command word for a given coordinate width.
    function automatic int cmd_bits(input int coord_bits);
        return 6 * coord_bits + 16;
    endfunction

    // Width of a raw pixel word for a given coordinate width.
    function automatic int raw_bits(input int coord_bits);
        return 2 * coord_bits + SLOT_BITS + 1;
    endfunction

    // Index modulo 12 by a reciprocal multiply, exact for all 8-bit inputs.
    function automatic logic [SLOT_BITS-1:0] color_slot(input logic [7:0] idx);
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  rem;
        prod = 16'(idx) * 16'd171;
        quot = prod[15:11];
        rem  = idx - 8'(quot) * 8'd12;
        return rem[SLOT_BITS-1:0];
    endfunction

endpackage

@@ rtl/line_pixel_generator.sv @@
`timescale 1ns / 1ps
// Bresenham line pixel generator.
// Input words enter through push/full. A start word (kind 0) carries both endpoints and a
// palette index and yields the first pixel of the line; each step word (kind 1) yields the
// next pixel, or nothing when no line is in progress. A start word drops any line in flight.
// Pixels leave through empty/pop: the oldest pixel sits on the result ports while empty is
// low, clamped to the frame and colored from the 12-entry palette.
// Frame width and height are written through i_cfg_we/i_cfg_index/i_cfg_data; the user
// must write them only while idle, which the block does not enforce. An accepted word
// passes the command queue, then the result queue, to the ports. One word is taken per
// cycle while the result queue has room. A two-word command queue separates setup from
// stepping and a two-word result queue holds finished pixels, so a stalled receiver fills
// the result queue, then the command queue, and full rises; no word is lost or repeated.
// Reset clears both queues and the line state and sets the frame to 1024 by 768.
// Reset takes effect at a rising edge with i_rst_n low.

module line_pixel_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_kind,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    input  logic [7:0]                          i_color_index,
    output logic                                empty,
    input  logic                                pop,
    output logic [lpg_pkg::PIXEL_BITS-1:0]      o_pixel_x,
    output logic [lpg_pkg::PIXEL_BITS-1:0]      o_pixel_y,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue,
    output logic                                o_last_pixel,
    input  logic                                i_cfg_we,
    input  logic [lpg_pkg::REG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [lpg_pkg::CFG_BITS-1:0]        i_cfg_data
);

    import lpg_pkg::*;

    localparam int CMD_BITS = cmd_bits(COORD_BITS);
    localparam int RAW_BITS = raw_bits(COORD_BITS);

    logic [CMD_BITS-1:0] front_cmd;
    logic [CMD_BITS-1:0] queued_cmd;
    logic                cmd_empty;
    logic                cmd_pop;
    logic [RAW_BITS-1:0] back_raw;
    logic [RAW_BITS-1:0] out_raw;
    logic                out_full;
    logic                out_push;

    lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_kind        (i_kind),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_color_index (i_color_index),
        .o_cmd         (front_cmd)
    );

    lpg_queue #(.WIDTH(CMD_BITS), .DEPTH(2)) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (queued_cmd),
        .o_empty (cmd_empty)
    );

    lpg_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queued_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_data  (back_raw)
    );

    lpg_queue #(.WIDTH(RAW_BITS), .DEPTH(2)) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_raw),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_raw),
        .o_empty (empty)
    );

    lpg_format #(.COORD_BITS(COORD_BITS)) u_format (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_raw        (out_raw),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_last_pixel (o_last_pixel)
    );

endmodule

@@ rtl/lpg_queue.sv @@
`timescale 1ns / 1ps

module lpg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/lpg_front.sv @@
`timescale 1ns / 1ps

module lpg_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                        i_kind,
    input  logic signed [COORD_BITS-1:0]                i_start_x,
    input  logic signed [COORD_BITS-1:0]                i_start_y,
    input  logic signed [COORD_BITS-1:0]                i_end_x,
    input  logic signed [COORD_BITS-1:0]                i_end_y,
    input  logic [7:0]                                  i_color_index,
    output logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0]    o_cmd
);

    import lpg_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    typedef struct packed {
        t_kind                         kind;
        logic                          x_major;
        logic                          minor_down;
        logic signed [COORD_BITS-1:0]  cur_x;
        logic signed [COORD_BITS-1:0]  cur_y;
        logic signed [COORD_BITS-1:0]  end_major;
        logic signed [EW-1:0]          err;
        logic signed [EW-1:0]          inc_straight;
        logic signed [EW-1:0]          inc_diagonal;
        logic [SLOT_BITS-1:0]          slot;
    } t_cmd;

    t_cmd                  cmd;
    logic signed [DW-1:0]  dx, dy, adx, ady;
    logic signed [EW-1:0]  adx_e, ady_e;
    logic                  same_sign;
    logic                  x_major;
    logic                  flip;

    always_comb begin
        dx        = DW'(i_end_x) - DW'(i_start_x);
        dy        = DW'(i_end_y) - DW'(i_start_y);
        adx       = dx[DW-1] ? -dx : dx;
        ady       = dy[DW-1] ? -dy : dy;
        adx_e     = EW'(adx);
        ady_e     = EW'(ady);
        same_sign = (dx[DW-1] && dy[DW-1])
                 || (!dx[DW-1] && (dx != '0) && !dy[DW-1] && (dy != '0));
        x_major   = (ady <= adx);
        flip      = x_major ? dx[DW-1] : dy[DW-1];

        cmd.kind       = t_kind'(i_kind);
        cmd.x_major    = x_major;
        cmd.minor_down = !same_sign;
        cmd.cur_x      = flip ? i_end_x : i_start_x;
        cmd.cur_y      = flip ? i_end_y : i_start_y;
        cmd.slot       = color_slot(i_color_index);
        if (x_major) begin
            cmd.err          = (ady_e <<< 1) - adx_e;
            cmd.inc_straight = ady_e <<< 1;
            cmd.inc_diagonal = (ady_e - adx_e) <<< 1;
            cmd.end_major    = flip ? i_start_x : i_end_x;
        end else begin
            cmd.err          = (adx_e <<< 1) - ady_e;
            cmd.inc_straight = adx_e <<< 1;
            cmd.inc_diagonal = (adx_e - ady_e) <<< 1;
            cmd.end_major    = flip ? i_start_y : i_end_y;
        end
    end

    assign o_cmd = cmd;

endmodule

@@ rtl/lpg_back.sv @@
`timescale 1ns / 1ps

module lpg_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0]    i_cmd,
    input  logic                                        i_cmd_empty,
    output logic                                        o_cmd_pop,
    input  logic                                        i_out_full,
    output logic                                        o_out_push,
    output logic [lpg_pkg::raw_bits(COORD_BITS)-1:0]    o_out_data
);

    import lpg_pkg::*;

    localparam int EW = COORD_BITS + 3;
    localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    typedef struct packed {
        t_kind                         kind;
        logic                          x_major;
        logic                          minor_down;
        logic signed [COORD_BITS-1:0]  cur_x;
        logic signed [COORD_BITS-1:0]  cur_y;
        logic signed [COORD_BITS-1:0]  end_major;
        logic signed [EW-1:0]          err;
        logic signed [EW-1:0]          inc_straight;
        logic signed [EW-1:0]          inc_diagonal;
        logic [SLOT_BITS-1:0]          slot;
    } t_cmd;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic [SLOT_BITS-1:0]          slot;
        logic                          last;
    } t_raw;

    t_cmd                          cmd;
    t_raw                          raw;
    logic                          take;
    logic                          emit;
    logic signed [COORD_BITS-1:0]  major;

    logic                          r_active, n_active;
    logic                          r_x_major, n_x_major;
    logic                          r_down, n_down;
    logic signed [COORD_BITS-1:0]  r_cur_x, n_cur_x;
    logic signed [COORD_BITS-1:0]  r_cur_y, n_cur_y;
    logic signed [COORD_BITS-1:0]  r_end_major, n_end_major;
    logic signed [EW-1:0]          r_err, n_err;
    logic signed [EW-1:0]          r_inc_s, n_inc_s;
    logic signed [EW-1:0]          r_inc_d, n_inc_d;
    logic [SLOT_BITS-1:0]          r_slot, n_slot;

    assign cmd  = t_cmd'(i_cmd);
    assign take = !i_cmd_empty && !i_out_full;

    always_comb begin
        n_x_major   = r_x_major;
        n_down      = r_down;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_end_major = r_end_major;
        n_err       = r_err;
        n_inc_s     = r_inc_s;
        n_inc_d     = r_inc_d;
        n_slot      = r_slot;
        emit        = 1'b0;
        if (cmd.kind == KIND_START) begin
            n_x_major   = cmd.x_major;
            n_down      = cmd.minor_down;
            n_cur_x     = cmd.cur_x;
            n_cur_y     = cmd.cur_y;
            n_end_major = cmd.end_major;
            n_err       = cmd.err;
            n_inc_s     = cmd.inc_straight;
            n_inc_d     = cmd.inc_diagonal;
            n_slot      = cmd.slot;
            emit        = 1'b1;
        end else if (r_active) begin
            emit = 1'b1;
            if (r_x_major) begin
                n_cur_x = r_cur_x + ONE;
                if (r_err[EW-1]) begin
                    n_err = r_err + r_inc_s;
                end else begin
                    n_cur_y = r_down ? r_cur_y - ONE : r_cur_y + ONE;
                    n_err   = r_err + r_inc_d;
                end
            end else begin
                n_cur_y = r_cur_y + ONE;
                if (r_err[EW-1] || (r_err == '0)) begin
                    n_err = r_err + r_inc_s;
                end else begin
                    n_cur_x = r_down ? r_cur_x - ONE : r_cur_x + ONE;
                    n_err   = r_err + r_inc_d;
                end
            end
        end
        major    = n_x_major ? n_cur_x : n_cur_y;
        n_active = emit ? (major < n_end_major) : r_active;
        raw.x    = n_cur_x;
        raw.y    = n_cur_y;
        raw.slot = n_slot;
        raw.last = !(major < n_end_major);
    end

    assign o_cmd_pop  = take;
    assign o_out_push = take && emit;
    assign o_out_data = raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (take) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x_major   <= n_x_major;
            r_down      <= n_down;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_end_major <= n_end_major;
            r_err       <= n_err;
            r_inc_s     <= n_inc_s;
            r_inc_d     <= n_inc_d;
            r_slot      <= n_slot;
        end
    end

endmodule

@@ rtl/lpg_format.sv @@
`timescale 1ns / 1ps

module lpg_format #(
    parameter int COORD_BITS = 12
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [lpg_pkg::REG_INDEX_BITS-1:0]          i_cfg_index,
    input  logic [lpg_pkg::CFG_BITS-1:0]                i_cfg_data,
    input  logic [lpg_pkg::raw_bits(COORD_BITS)-1:0]    i_raw,
    output logic [lpg_pkg::PIXEL_BITS-1:0]              o_pixel_x,
    output logic [lpg_pkg::PIXEL_BITS-1:0]              o_pixel_y,
    output logic [7:0]                                  o_red,
    output logic [7:0]                                  o_green,
    output logic [7:0]                                  o_blue,
    output logic                                        o_last_pixel
);

    import lpg_pkg::*;

    localparam int KW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic [SLOT_BITS-1:0]          slot;
        logic                          last;
    } t_raw;

    t_raw                  raw;
    t_color                color;
    logic [CFG_BITS-1:0]   r_width, n_width;
    logic [CFG_BITS-1:0]   r_height, n_height;

    // Negative coordinates and an empty frame give zero; sizes above the maximum saturate.
    function automatic logic [PIXEL_BITS-1:0] clamp(
        input logic signed [COORD_BITS-1:0] v,
        input logic [CFG_BITS-1:0]          size
    );
        logic [CFG_BITS-1:0] eff;
        logic [KW-1:0]       mag;
        logic [KW-1:0]       lim;
        logic [KW-1:0]       res;
        eff = (size > FRAME_MAX) ? FRAME_MAX : size;
        mag = KW'(unsigned'(v));
        lim = KW'(eff);
        if (v[COORD_BITS-1] || (eff == '0)) begin
            res = '0;
        end else if (mag >= lim) begin
            res = lim - KW'(1);
        end else begin
            res = mag;
        end
        return res[PIXEL_BITS-1:0];
    endfunction

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_FRAME_WIDTH:  n_width  = i_cfg_data;
                REG_FRAME_HEIGHT: n_height = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign raw          = t_raw'(i_raw);
    assign color        = PALETTE[raw.slot];
    assign o_pixel_x    = clamp(raw.x, r_width);
    assign o_pixel_y    = clamp(raw.y, r_height);
    assign o_red        = color.red;
    assign o_green      = color.green;
    assign o_blue       = color.blue;
    assign o_last_pixel = raw.last;

endmodule

@@ rtl/lpg_checker.sv @@
`timescale 1ns / 1ps
`include "line_pixel_generator_defines.svh"

module lpg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_last_pixel
);

    // After reset the result queue is empty and the command queue is not full.
    `LPG_ASSERT_RST(a_reset_empty, !i_rst_n, empty && !full, "queues not empty after reset")

    // The command queue only backs up while results are waiting.
    `LPG_ASSERT_IMP(a_full_has_result, full, !empty, "input full with no result waiting")

    // A waiting word that is not taken stays on the ports unchanged.
    `LPG_ASSERT_NXT(a_stall_holds, !empty && !pop,
        !empty && $stable(o_red) && $stable(o_green) && $stable(o_blue)
        && $stable(o_last_pixel), "stalled result word changed")

endmodule

bind line_pixel_generator lpg_checker u_checker (.*);

@@ tb/line_pixel_generator_checker.sv @@
`timescale 1ns / 1ps

module lpg_pixel_checker #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic                                i_kind,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    input  logic [7:0]                          i_color_index,
    input  logic                                empty,
    input  logic                                pop,
    input  logic [lpg_pkg::PIXEL_BITS-1:0]      i_pixel_x,
    input  logic [lpg_pkg::PIXEL_BITS-1:0]      i_pixel_y,
    input  logic [7:0]                          i_red,
    input  logic [7:0]                          i_green,
    input  logic [7:0]                          i_blue,
    input  logic                                i_last_pixel,
    input  logic                                i_cfg_we,
    input  logic [lpg_pkg::REG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [lpg_pkg::CFG_BITS-1:0]        i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_predicted,
    output int                                  o_checked,
    output int                                  o_full_stalls
);

    import lpg_pkg::*;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] x;
        logic [PIXEL_BITS-1:0] y;
        t_color                color;
        logic                  last;
    } t_pixel;

    int     frame_w = int'(WIDTH_RESET);
    int     frame_h = int'(HEIGHT_RESET);
    logic   line_on;
    logic   x_major;
    logic   step_down;
    int     cur_x;
    int     cur_y;
    int     end_major;
    int     err;
    int     inc_straight;
    int     inc_diag;
    int     slot;
    t_pixel pixels_due[$];
    int     fails = 0;
    int     predicted = 0;
    int     checked = 0;
    int     stalls = 0;

    function automatic logic [PIXEL_BITS-1:0] clamp_to_frame(int v, int size);
        int hi;
        hi = ((size > int'(FRAME_MAX)) ? int'(FRAME_MAX) : size) - 1;
        if (v > hi) begin
            v = hi;
        end
        if (v < 0) begin
            v = 0;
        end
        return v[PIXEL_BITS-1:0];
    endfunction

    task automatic queue_pixel();
        t_pixel p;
        p.x     = clamp_to_frame(cur_x, frame_w);
        p.y     = clamp_to_frame(cur_y, frame_h);
        p.color = PALETTE[slot];
        p.last  = !line_on;
        pixels_due.push_back(p);
        predicted++;
    endtask

    task automatic start_line(input int x1, input int y1, input int x2, input int y2,
                              input int ci);
        int dx;
        int dy;
        int adx;
        int ady;
        dx        = x2 - x1;
        dy        = y2 - y1;
        adx       = (dx < 0) ? -dx : dx;
        ady       = (dy < 0) ? -dy : dy;
        slot      = ci % PALETTE_SIZE;
        step_down = !((dx < 0 && dy < 0) || (dx > 0 && dy > 0));
        x_major   = (ady <= adx);
        if (x_major) begin
            err          = 2 * ady - adx;
            inc_straight = 2 * ady;
            inc_diag     = 2 * (ady - adx);
            if (dx >= 0) begin
                cur_x = x1; cur_y = y1; end_major = x2;
            end else begin
                cur_x = x2; cur_y = y2; end_major = x1;
            end
            line_on = (cur_x < end_major);
        end else begin
            err          = 2 * adx - ady;
            inc_straight = 2 * adx;
            inc_diag     = 2 * (adx - ady);
            if (dy >= 0) begin
                cur_x = x1; cur_y = y1; end_major = y2;
            end else begin
                cur_x = x2; cur_y = y2; end_major = y1;
            end
            line_on = (cur_y < end_major);
        end
        queue_pixel();
    endtask

    task automatic step_line();
        if (!line_on) begin
            return;
        end
        if (x_major) begin
            cur_x++;
            if (err < 0) begin
                err += inc_straight;
            end else begin
                cur_y += step_down ? -1 : 1;
                err   += inc_diag;
            end
            line_on = (cur_x < end_major);
        end else begin
            cur_y++;
            if (err <= 0) begin
                err += inc_straight;
            end else begin
                cur_x += step_down ? -1 : 1;
                err   += inc_diag;
            end
            line_on = (cur_y < end_major);
        end
        queue_pixel();
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            fails++;
        end
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (pixels_due.size() == 0) begin
            $display("%0t: pixel (%0d, %0d) popped with no pixel expected",
                     $time, i_pixel_x, i_pixel_y);
            fails++;
        end else begin
            want = pixels_due.pop_front();
            compare_field("pixel_x", want.x, i_pixel_x);
            compare_field("pixel_y", want.y, i_pixel_y);
            compare_field("red", want.color.red, i_red);
            compare_field("green", want.color.green, i_green);
            compare_field("blue", want.color.blue, i_blue);
            compare_field("last_pixel", want.last, i_last_pixel);
            checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_w      = int'(WIDTH_RESET);
            frame_h      = int'(HEIGHT_RESET);
            line_on      = 1'b0;
            x_major      = 1'b0;
            step_down    = 1'b0;
            cur_x        = 0;
            cur_y        = 0;
            end_major    = 0;
            err          = 0;
            inc_straight = 0;
            inc_diag     = 0;
            slot         = 0;
            pixels_due.delete();
        end else begin
            if (pop && !empty) begin
                check_pixel();
            end
            if (push && !full) begin
                if (i_kind == KIND_START) begin
                    start_line(i_start_x, i_start_y, i_end_x, i_end_y, int'(i_color_index));
                end else begin
                    step_line();
                end
            end else if (push) begin
                stalls++;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    frame_w = int'(i_cfg_data);
                end else begin
                    frame_h = int'(i_cfg_data);
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= pixels_due.size();
        o_predicted   <= predicted;
        o_checked     <= checked;
        o_full_stalls <= stalls;
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import lpg_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_LEN   = 400;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        i_kind = KIND_START;
    logic signed [COORD_BITS-1:0] start_x = '0;
    logic signed [COORD_BITS-1:0] start_y = '0;
    logic signed [COORD_BITS-1:0] end_x = '0;
    logic signed [COORD_BITS-1:0] end_y = '0;
    logic [7:0]                  color_index = '0;
    logic                        pop = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [REG_INDEX_BITS-1:0]   cfg_index = REG_FRAME_WIDTH;
    logic [CFG_BITS-1:0]         cfg_data = '0;

    logic                        full;
    logic                        empty;
    logic [PIXEL_BITS-1:0]       pixel_x;
    logic [PIXEL_BITS-1:0]       pixel_y;
    logic [7:0]                  red;
    logic [7:0]                  green;
    logic [7:0]                  blue;
    logic                        last_pixel;

    int fail_count;
    int pending;
    int predicted;
    int checked;
    int full_stalls;

    int cfg_w = int'(WIDTH_RESET);
    int cfg_h = int'(HEIGHT_RESET);
    int words_sent = 0;
    int lines_sent = 0;
    int settings_used = 1;
    bit quiet = 1'b0;
    bit draining = 1'b0;
    bit hold_done = 1'b0;

    line_pixel_generator #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_end_x      (end_x),
        .i_end_y      (end_y),
        .i_color_index(color_index),
        .empty        (empty),
        .pop          (pop),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue),
        .o_last_pixel (last_pixel),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    lpg_pixel_checker #(
        .COORD_BITS(COORD_BITS)
    ) pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_end_x      (end_x),
        .i_end_y      (end_y),
        .i_color_index(color_index),
        .empty        (empty),
        .pop          (pop),
        .i_pixel_x    (pixel_x),
        .i_pixel_y    (pixel_y),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .i_last_pixel (last_pixel),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_predicted  (predicted),
        .o_checked    (checked),
        .o_full_stalls(full_stalls)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic int fit_coord(int v);
        if (v > 2047) begin
            v = 2047;
        end
        if (v < -2048) begin
            v = -2048;
        end
        return v;
    endfunction

    // Coordinates cluster around zero and the far frame border to exercise clamping.
    function automatic int rand_coord(int size);
        int v;
        case ($urandom_range(0, 3))
            0:       v = int'($urandom_range(0, 40)) - 20;
            1:       v = size + int'($urandom_range(0, 40)) - 20;
            default: v = int'($urandom_range(0, 4095)) - 2048;
        endcase
        return fit_coord(v);
    endfunction

    task automatic send_word(input t_kind kind, input int sx, input int sy, input int ex,
                             input int ey, input int ci);
        if (!quiet && $urandom_range(0, 99) < 20) begin
            push <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_kind      <= kind;
        start_x     <= sx[COORD_BITS-1:0];
        start_y     <= sy[COORD_BITS-1:0];
        end_x       <= ex[COORD_BITS-1:0];
        end_y       <= ey[COORD_BITS-1:0];
        color_index <= ci[7:0];
        do @(posedge i_clk); while (full);
        words_sent++;
    endtask

    task automatic send_step();
        send_word(KIND_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255));
    endtask

    task automatic drain();
        draining = 1'b1;
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        draining = 1'b0;
    endtask

    task automatic write_frame(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w[CFG_BITS-1:0];
        @(posedge i_clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h[CFG_BITS-1:0];
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cfg_w = w;
        cfg_h = h;
    endtask

    // Mostly complete lines, some cut short by a new start, a few long ones abandoned.
    task automatic send_line();
        int mode;
        int reach;
        int sx;
        int sy;
        int ex;
        int ey;
        int span;
        int steps;
        quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 3)) send_step();
        end
        mode = $urandom_range(0, 99);
        sx   = rand_coord(cfg_w);
        sy   = rand_coord(cfg_h);
        if (mode < 4) begin
            ex = int'($urandom_range(0, 4095)) - 2048;
            ey = int'($urandom_range(0, 4095)) - 2048;
        end else begin
            reach = ($urandom_range(0, 9) == 0) ? 300 : 24;
            ex = fit_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
            ey = fit_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
        end
        span = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > span) begin
            span = (ey > sy) ? ey - sy : sy - ey;
        end
        if (mode < 4) begin
            steps = $urandom_range(0, 12);
        end else if (mode < 14) begin
            steps = $urandom_range(0, span);
        end else begin
            steps = span + $urandom_range(0, 2);
        end
        send_word(KIND_START, sx, sy, ex, ey, $urandom_range(0, 255));
        lines_sent++;
        repeat (steps) send_step();
    endtask

    initial begin
        int stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && words_sent >= HOLD_AT && !draining) begin
                hold_done = 1'b1;
                stall = HOLD_LEN;
            end else if (stall == 0 && !quiet && $urandom_range(0, 99) < 15) begin
                stall = idle_len();
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        #5ms;
        $display("Timeout with %0d pixels still expected.", pending);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int phase_w [8];
        int phase_h [8];
        int w;
        int h;
        int goal;
        int wait_cycles;
        phase_w = '{2048, 1, 0, 4095, 640, 0, 2047, 1024};
        phase_h = '{2048, 1, 4095, 0, 480, 0, 2, 768};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Step with no line in progress, then a single-pixel line.
        send_step();
        send_word(KIND_START, 0, 0, 0, 0, 255);
        // Extreme endpoints; the first line is dropped by the next start.
        send_word(KIND_START, -2048, -2048, 2047, 2047, 0);
        send_word(KIND_START, 2047, -2048, -2048, 2047, 128);
        repeat (3) send_step();
        // Reversed x-major line with the minor axis stepping down.
        send_word(KIND_START, 5, 3, -4, 6, 11);
        repeat (4) send_step();
        // Y-major lines, one with mixed signs and one with both deltas negative.
        send_word(KIND_START, 1, -5, -2, 4, 23);
        repeat (3) send_step();
        send_word(KIND_START, 3, 3, 1, -4, 70);
        repeat (2) send_step();
        // Vertical line run to its end, plus a step after it has finished.
        send_word(KIND_START, 7, 0, 7, 2, 131);
        repeat (3) send_step();

        for (int p = 0; p < 8; p++) begin
            drain();
            w = (p == 5) ? $urandom_range(1, 2048) : phase_w[p];
            h = (p == 5) ? $urandom_range(1, 2048) : phase_h[p];
            write_frame(w, h);
            settings_used++;
            goal = predicted + 250;
            while (predicted < goal) send_line();
        end

        push <= 1'b0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (pending != 0) begin
            $display("%0t: %0d expected pixels never arrived", $time, pending);
        end
        $display("Drew %0d lines from %0d words, %0d pixels checked under %0d frame sizes.",
                 lines_sent, words_sent, checked, settings_used);
        $display("Input was held off by full on %0d cycles.", full_stalls);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
